@@ rtl/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes of the slot store table
// Command and status codes, ring control group and response record.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam logic [2:0] CMD_STORE  = 3'd0;
	localparam logic [2:0] CMD_LOOKUP = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_DUMP   = 3'd4;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

	localparam int MAX_RESULTS = 16;

	typedef struct packed {
		logic shift;
		logic clear;
		logic head_wr;
		logic head_kill;
	} ring_ctrl_t;

	typedef struct packed {
		logic        status;
		logic [63:0] out_id;
		logic [31:0] out_payload;
		logic [3:0]  slot_index;
		logic [4:0]  free_count;
		logic        last;
	} rsp_t;

endpackage

@@ rtl/sst_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cfg_if: configuration write channel
// Carries the usable slot count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sst_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sst_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_req_if: command channel
// Carries one command with identifier and payload per transaction.
// ----------------------------------------------------------------------------
interface sst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [63:0] item_id;
	logic [31:0] item_payload;

	modport source (output valid, output cmd, output item_id, output item_payload, input ready);
	modport sink (input valid, input cmd, input item_id, input item_payload, output ready);
endinterface

@@ rtl/sst_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_rsp_if: response channel
// Carries one result record per transaction.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [63:0] out_id;
	logic [31:0] out_payload;
	logic [3:0]  slot_index;
	logic [4:0]  free_count;
	logic        last;

	modport source (output valid, output status, output out_id, output out_payload,
		output slot_index, output free_count, output last, input ready);
	modport sink (input valid, input status, input out_id, input out_payload,
		input slot_index, input free_count, input last, output ready);
endinterface

@@ rtl/sst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one slot of the rotating table
// Holds valid mark, identifier and payload; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module sst_cell #(
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sst_pkg::ring_ctrl_t     ctrl,
	input  logic                    nxt_valid,
	input  logic [63:0]             nxt_id,
	input  logic [PAYLOAD_BITS-1:0] nxt_payload,
	output logic                    cur_valid,
	output logic [63:0]             cur_id,
	output logic [PAYLOAD_BITS-1:0] cur_payload
);
	import sst_pkg::*;

	logic                    valid_q;
	logic [63:0]             id_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q      <= nxt_id;
			payload_q <= nxt_payload;
		end
	end

	assign cur_valid   = valid_q;
	assign cur_id      = id_q;
	assign cur_payload = payload_q;

endmodule

@@ rtl/sst_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ring: circular chain of slot cells
// Rotates entries one cell per shift; the head entry is updated as it wraps.
// ----------------------------------------------------------------------------
module sst_ring #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sst_pkg::ring_ctrl_t     ctrl,
	input  logic [63:0]             wr_id,
	input  logic [PAYLOAD_BITS-1:0] wr_payload,
	output logic                    head_valid,
	output logic [63:0]             head_id,
	output logic [PAYLOAD_BITS-1:0] head_payload
);
	import sst_pkg::*;

	logic                    c_valid [SLOTS];
	logic [63:0]             c_id    [SLOTS];
	logic [PAYLOAD_BITS-1:0] c_pl    [SLOTS];

	logic                    wrap_valid;
	logic [63:0]             wrap_id;
	logic [PAYLOAD_BITS-1:0] wrap_pl;

	always_comb begin
		wrap_valid = c_valid[0];
		wrap_id    = c_id[0];
		wrap_pl    = c_pl[0];
		if (ctrl.head_wr) begin
			wrap_valid = 1'b1;
			wrap_id    = wr_id;
			wrap_pl    = wr_payload;
		end else if (ctrl.head_kill) begin
			wrap_valid = 1'b0;
		end
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		if (k == SLOTS - 1) begin : g_tail
			sst_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.nxt_valid   (wrap_valid),
				.nxt_id      (wrap_id),
				.nxt_payload (wrap_pl),
				.cur_valid   (c_valid[k]),
				.cur_id      (c_id[k]),
				.cur_payload (c_pl[k])
			);
		end else begin : g_body
			sst_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.nxt_valid   (c_valid[k+1]),
				.nxt_id      (c_id[k+1]),
				.nxt_payload (c_pl[k+1]),
				.cur_valid   (c_valid[k]),
				.cur_id      (c_id[k]),
				.cur_payload (c_pl[k])
			);
		end
	end

	assign head_valid   = c_valid[0];
	assign head_id      = c_id[0];
	assign head_payload = c_pl[0];

endmodule

@@ rtl/slot_store_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_store_table: fixed-slot associative table
// Store, lookup, remove, clear and dump over a ring of slot cells.
// ----------------------------------------------------------------------------
// The slots sit in a ring of SLOTS cells that rotates one place per cycle past
// a head cell while a command scans, unless a dump pauses it; each store,
// lookup, remove or dump looks at one slot per cycle in slot order. Store,
// lookup and remove are accepted, turn the ring once and post the result from a
// finish state. A dump that finds entries posts each one as the ring passes it;
// an empty dump posts its failure from the finish state. A dump pauses the ring
// while its response register is still held by the sink. Clear and unknown
// commands go straight to the finish state; a clear drops only the valid marks.
// A write of the usable slot count also drops every valid mark. Posting a result
// waits while the sink still holds the response register. Only one command is in
// work at a time; the next one is taken while the last result still waits in the
// response register. Reset leaves the table empty with no usable slots.
// ----------------------------------------------------------------------------
module slot_store_table #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sst_cfg_if.sink   cfg,
	sst_req_if.sink   req,
	sst_rsp_if.source rsp
);
	import sst_pkg::*;

	localparam int NW = $clog2(SLOTS + 1);
	localparam int EW = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]              state_q;
	logic [4:0]              cfg_q;
	logic [2:0]              cmd_q;
	logic [NW-1:0]           cnt_q;
	logic [NW-1:0]           occ_q;
	logic [EW-1:0]           emit_q;
	logic [EW-1:0]           total_q;
	logic                    hit_q;
	logic                    out_valid_q;
	logic [63:0]             id_q;
	logic [PAYLOAD_BITS-1:0] pl_q;
	logic [NW-1:0]           hit_idx_q;
	logic [63:0]             hit_id_q;
	logic [31:0]             hit_pl_q;
	rsp_t                    pend_q;
	rsp_t                    out_q;

	logic                    head_valid;
	logic [63:0]             head_id;
	logic [PAYLOAD_BITS-1:0] head_payload;
	ring_ctrl_t              rc;

	logic          req_fire;
	logic          cfg_fire;
	logic          out_free;
	logic [NW-1:0] n_eff;
	logic          scanning;
	logic          in_use;
	logic          cand_store;
	logic          cand_find;
	logic          cand_dump;
	logic          dump_emit;
	logic          step;
	logic          scan_end;
	logic          hit_now;
	logic [NW-1:0] idx_now;
	logic [63:0]   hid_now;
	logic [31:0]   hpl_now;
	logic [NW-1:0] occ_d;
	logic [EW-1:0] emit_d;
	logic [4:0]    free_now;
	rsp_t          pend_scan;
	rsp_t          dump_rsp;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign n_eff = (32'(cfg_q) > 32'(SLOTS)) ? NW'(SLOTS) : NW'(cfg_q);

	assign scanning   = (state_q == S_SCAN);
	assign in_use     = cnt_q < n_eff;
	assign cand_store = scanning && (cmd_q == CMD_STORE) && in_use && !head_valid && !hit_q;
	assign cand_find  = scanning && ((cmd_q == CMD_LOOKUP) || (cmd_q == CMD_REMOVE)) &&
		in_use && head_valid && (head_id == id_q) && !hit_q;
	assign cand_dump  = scanning && (cmd_q == CMD_DUMP) && in_use && head_valid &&
		(emit_q < EW'(MAX_RESULTS));
	assign dump_emit  = cand_dump && out_free;
	assign step       = scanning && !(cand_dump && !out_free);
	assign scan_end   = step && (cnt_q == NW'(SLOTS - 1));

	assign hit_now = hit_q || cand_store || cand_find;
	assign idx_now = (cand_store || cand_find) ? cnt_q : hit_idx_q;
	assign hid_now = cand_store ? id_q : (cand_find ? head_id : hit_id_q);
	assign hpl_now = cand_store ? 32'(pl_q) : (cand_find ? 32'(head_payload) : hit_pl_q);
	assign emit_d  = emit_q + EW'(dump_emit);

	always_comb begin
		occ_d = occ_q;
		if (cfg_fire || (req_fire && (req.cmd == CMD_CLEAR))) begin
			occ_d = '0;
		end else if (cand_store) begin
			occ_d = occ_q + NW'(1);
		end else if (cand_find && (cmd_q == CMD_REMOVE)) begin
			occ_d = occ_q - NW'(1);
		end
	end

	assign free_now = 5'(n_eff - occ_d);

	always_comb begin
		pend_scan.status      = hit_now ? STAT_OK : STAT_FAIL;
		pend_scan.out_id      = hit_now ? hid_now : 64'd0;
		pend_scan.out_payload = hit_now ? hpl_now : 32'd0;
		pend_scan.slot_index  = hit_now ? 4'(idx_now) : 4'd0;
		pend_scan.free_count  = free_now;
		pend_scan.last        = 1'b1;

		dump_rsp.status      = STAT_OK;
		dump_rsp.out_id      = head_id;
		dump_rsp.out_payload = 32'(head_payload);
		dump_rsp.slot_index  = 4'(cnt_q);
		dump_rsp.free_count  = free_now;
		dump_rsp.last        = (emit_d == total_q);
	end

	assign rc.shift     = step;
	assign rc.clear     = cfg_fire || (req_fire && (req.cmd == CMD_CLEAR));
	assign rc.head_wr   = cand_store;
	assign rc.head_kill = cand_find && (cmd_q == CMD_REMOVE);

	sst_ring #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (rc),
		.wr_id        (id_q),
		.wr_payload   (pl_q),
		.head_valid   (head_valid),
		.head_id      (head_id),
		.head_payload (head_payload)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= '0;
			cmd_q       <= CMD_STORE;
			cnt_q       <= '0;
			occ_q       <= '0;
			emit_q      <= '0;
			total_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (cfg_fire) begin
				cfg_q <= cfg.data;
			end
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dump_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cmd_q   <= req.cmd;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						emit_q  <= '0;
						total_q <= (32'(occ_q) >= MAX_RESULTS) ? EW'(MAX_RESULTS) : EW'(occ_q);
						if ((req.cmd == CMD_CLEAR) || (req.cmd > CMD_DUMP)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (step) begin
						cnt_q  <= cnt_q + NW'(1);
						hit_q  <= hit_now;
						emit_q <= emit_d;
						if (scan_end) begin
							if ((cmd_q == CMD_DUMP) && (emit_d != '0)) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_FINISH;
							end
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q <= req.item_id;
			pl_q <= PAYLOAD_BITS'(req.item_payload);
			pend_q.status      <= (req.cmd == CMD_CLEAR) ? STAT_OK : STAT_FAIL;
			pend_q.out_id      <= 64'd0;
			pend_q.out_payload <= 32'd0;
			pend_q.slot_index  <= 4'd0;
			pend_q.free_count  <= free_now;
			pend_q.last        <= 1'b1;
		end
		if (step) begin
			hit_idx_q <= idx_now;
			hit_id_q  <= hid_now;
			hit_pl_q  <= hpl_now;
		end
		if (scan_end) begin
			pend_q <= pend_scan;
		end
		if ((state_q == S_FINISH) && out_free) begin
			out_q <= pend_q;
		end else if (dump_emit) begin
			out_q <= dump_rsp;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.out_id      = out_q.out_id;
	assign rsp.out_payload = out_q.out_payload;
	assign rsp.slot_index  = out_q.slot_index;
	assign rsp.free_count  = out_q.free_count;
	assign rsp.last        = out_q.last;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= n_eff)
		else $error("occupied count above usable slots");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q < NW'(SLOTS)))
		else $error("scan position past the ring");

	a_finish_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINISH) && out_free) |=> (state_q == S_IDLE) && out_valid_q)
		else $error("pending result not posted");

	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		dump_emit |-> (emit_q < total_q))
		else $error("dump emits more entries than occupied");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the slot store table
// A queue-fed driver sends store, lookup, remove, clear, dump and unknown
// commands with random gaps, and a monitor with random stalls compares every
// response with the one that a behavioral copy of the table predicts. The
// usable slot count is rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import sst_pkg::*;

	localparam int TBL_SLOTS = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [2:0] CMD_BAD_A = 3'd5;
	localparam logic [2:0] CMD_BAD_B = 3'd6;
	localparam logic [2:0] CMD_BAD_C = 3'd7;
	localparam logic [63:0] ID_ONES = {64{1'b1}};
	localparam logic [31:0] PL_ONES = {32{1'b1}};

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] id;
		logic [31:0] pl;
		bit          drain;
	} table_op_t;

	logic clk = 1'b0;
	logic arst_n;

	sst_cfg_if cfg_ch ();
	sst_req_if req_ch ();
	sst_rsp_if rsp_ch ();

	slot_store_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	table_op_t   op_queue [$];
	rsp_t        expected_rsp [$];
	logic [4:0]  cap_q;
	bit          s_valid [TBL_SLOTS];
	logic [63:0] s_id [TBL_SLOTS];
	logic [31:0] s_pl [TBL_SLOTS];
	int          mismatch_count = 0;
	bit          no_idle = 1'b0;
	int          gap;
	int          stall;

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic int live_slots();
		return (cap_q > TBL_SLOTS) ? TBL_SLOTS : int'(cap_q);
	endfunction

	function automatic void drop_all();
		foreach (s_valid[i])
			s_valid[i] = 1'b0;
	endfunction

	function automatic void push_rsp(input logic st, input logic [63:0] id,
			input logic [31:0] pl, input int idx, input logic lst);
		rsp_t r;
		int   used;
		used = 0;
		for (int i = 0; i < live_slots(); i++)
			if (s_valid[i])
				used++;
		r.status      = st;
		r.out_id      = id;
		r.out_payload = pl;
		r.slot_index  = 4'(idx);
		r.free_count  = 5'(live_slots() - used);
		r.last        = lst;
		expected_rsp.insert(expected_rsp.size(), r);
	endfunction

	function automatic void apply_table_op(input logic [2:0] op, input logic [63:0] id,
			input logic [31:0] pl);
		int n;
		int hit;
		int k;
		int tail;
		n    = live_slots();
		hit  = -1;
		k    = 0;
		tail = -1;
		case (op)
			CMD_STORE: begin
				for (int i = 0; i < n; i++)
					if (!s_valid[i] && hit < 0)
						hit = i;
				if (hit < 0) begin
					push_rsp(STAT_FAIL, '0, '0, 0, 1'b1);
				end else begin
					s_valid[hit] = 1'b1;
					s_id[hit]    = id;
					s_pl[hit]    = pl;
					push_rsp(STAT_OK, id, pl, hit, 1'b1);
				end
			end
			CMD_LOOKUP, CMD_REMOVE: begin
				for (int i = 0; i < n; i++)
					if (s_valid[i] && s_id[i] == id && hit < 0)
						hit = i;
				if (hit < 0) begin
					push_rsp(STAT_FAIL, '0, '0, 0, 1'b1);
				end else begin
					if (op == CMD_REMOVE)
						s_valid[hit] = 1'b0;
					push_rsp(STAT_OK, s_id[hit], s_pl[hit], hit, 1'b1);
				end
			end
			CMD_CLEAR: begin
				drop_all();
				push_rsp(STAT_OK, '0, '0, 0, 1'b1);
			end
			CMD_DUMP: begin
				for (int i = 0; i < n; i++)
					if (s_valid[i] && k < MAX_RESULTS) begin
						k++;
						tail = i;
					end
				if (tail < 0) begin
					push_rsp(STAT_FAIL, '0, '0, 0, 1'b1);
				end else begin
					for (int i = 0; i <= tail; i++)
						if (s_valid[i])
							push_rsp(STAT_OK, s_id[i], s_pl[i], i, i == tail);
				end
			end
			default: begin
				push_rsp(STAT_FAIL, '0, '0, 0, 1'b1);
			end
		endcase
	endfunction

	// command driver
	always @(posedge clk) begin
		int        g;
		bit        hold;
		table_op_t op;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap <= 0;
		end else begin
			g = gap;
			hold = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				apply_table_op(req_ch.cmd, req_ch.item_id, req_ch.item_payload);
				g = idle_draw();
			end
			if (!hold) begin
				if (g > 0) begin
					req_ch.valid <= 1'b0;
					gap <= g - 1;
				end else if (op_queue.size() == 0 ||
						(op_queue[0].drain && expected_rsp.size() != 0)) begin
					req_ch.valid <= 1'b0;
				end else begin
					op = op_queue.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.cmd          <= op.cmd;
					req_ch.item_id      <= op.id;
					req_ch.item_payload <= op.pl;
					gap <= 0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		int   w;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.status, rsp_ch.out_id, rsp_ch.out_payload,
				rsp_ch.slot_index, rsp_ch.free_count, rsp_ch.last};
			if (expected_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t unexpected response st=%0d id=%h pl=%h slot=%0d free=%0d last=%0d",
						$realtime, got.status, got.out_id, got.out_payload,
						got.slot_index, got.free_count, got.last);
			end else begin
				want = expected_rsp.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t mismatch want st=%0d id=%h pl=%h slot=%0d free=%0d last=%0d",
							$realtime, want.status, want.out_id, want.out_payload,
							want.slot_index, want.free_count, want.last);
						$display("%0t          got  st=%0d id=%h pl=%h slot=%0d free=%0d last=%0d",
							$realtime, got.status, got.out_id, got.out_payload,
							got.slot_index, got.free_count, got.last);
					end
				end
			end
			w = idle_draw();
			rsp_ch.ready <= (w == 0);
			stall <= w;
		end else if (stall > 0) begin
			stall <= stall - 1;
			rsp_ch.ready <= (stall == 1);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic queue_op(input logic [2:0] cmd, input logic [63:0] id,
			input logic [31:0] pl, input bit drain);
		table_op_t op;
		op.cmd   = cmd;
		op.id    = id;
		op.pl    = pl;
		op.drain = drain;
		op_queue.insert(op_queue.size(), op);
	endtask

	task automatic wait_idle();
		while (op_queue.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_usable(input logic [4:0] v);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cap_q = v;
		drop_all();
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_random(input int count);
		logic [63:0] pool [6];
		logic [63:0] id;
		logic [2:0]  cmd;
		int          r;
		foreach (pool[i])
			pool[i] = {$urandom, $urandom};
		pool[0] = ($urandom_range(0, 1) == 0) ? '0 : ID_ONES;
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(0, 99);
			if (r < 38)
				cmd = CMD_STORE;
			else if (r < 62)
				cmd = CMD_LOOKUP;
			else if (r < 82)
				cmd = CMD_REMOVE;
			else if (r < 90)
				cmd = CMD_DUMP;
			else if (r < 94)
				cmd = CMD_CLEAR;
			else
				cmd = 3'($urandom_range(CMD_BAD_A, CMD_BAD_C));
			id = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)]
				: {$urandom, $urandom};
			queue_op(cmd, id, $urandom, $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		logic [4:0] caps [8];
		caps = '{5'd4, 5'd16, 5'd1, 5'd0, 5'd9, 5'd16, 5'd2, 5'd20};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_STORE;
		req_ch.item_id = '0;
		req_ch.item_payload = '0;
		rsp_ch.ready = 1'b0;
		cap_q = '0;
		drop_all();
		foreach (s_id[i]) begin
			s_id[i] = '0;
			s_pl[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// no usable slots out of reset
		queue_op(CMD_STORE, ID_ONES, PL_ONES, 1'b0);
		queue_op(CMD_DUMP, '0, '0, 1'b0);
		queue_op(CMD_BAD_A, ID_ONES, PL_ONES, 1'b0);

		set_usable(5'd16);
		queue_op(CMD_STORE, '0, '0, 1'b0);
		queue_op(CMD_STORE, ID_ONES, PL_ONES, 1'b0);
		queue_op(CMD_STORE, ID_ONES, 32'h5a5a_a5a5, 1'b0);
		queue_op(CMD_LOOKUP, ID_ONES, '0, 1'b0);
		queue_op(CMD_REMOVE, ID_ONES, '0, 1'b0);
		queue_op(CMD_LOOKUP, ID_ONES, '0, 1'b0);
		queue_op(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 1'b0);
		queue_op(CMD_REMOVE, 64'h0123_4567_89ab_cdef, '0, 1'b0);
		queue_op(CMD_STORE, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1);
		queue_op(CMD_DUMP, '0, '0, 1'b0);
		queue_op(CMD_CLEAR, ID_ONES, PL_ONES, 1'b0);
		queue_op(CMD_DUMP, '0, '0, 1'b0);
		queue_op(CMD_BAD_B, '0, '0, 1'b0);
		queue_op(CMD_BAD_C, ID_ONES, PL_ONES, 1'b0);
		queue_op(CMD_STORE, 64'hdead_beef_0000_ffff, PL_ONES, 1'b0);

		// rewrite drops the stored entry; oversized count acts as the full table
		set_usable(5'd31);
		queue_op(CMD_DUMP, '0, '0, 1'b0);
		queue_op(CMD_LOOKUP, 64'hdead_beef_0000_ffff, '0, 1'b0);
		for (int i = 0; i < TBL_SLOTS + 1; i++)
			queue_op(CMD_STORE, {$urandom, $urandom}, $urandom, 1'b0);
		queue_op(CMD_DUMP, '0, '0, 1'b0);
		queue_random(12);

		foreach (caps[p]) begin
			set_usable(caps[p]);
			no_idle = (p == 1 || p == 5);
			if (caps[p] == 5'd0) begin
				queue_random(8);
			end else begin
				for (int i = 0; i < caps[p]; i++)
					queue_op(CMD_STORE, {$urandom, $urandom}, $urandom, 1'b0);
				queue_op(CMD_DUMP, '0, '0, 1'b0);
				queue_random(14);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp.size() == 0)
			$display("slot_store_table regression: pass");
		else
			$display("slot_store_table regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("slot_store_table regression: fail");
		$finish;
	end

endmodule

@@ slot_store_table.f @@
rtl/sst_pkg.sv
rtl/sst_cfg_if.sv
rtl/sst_req_if.sv
rtl/sst_rsp_if.sv
rtl/sst_cell.sv
rtl/sst_ring.sv
rtl/slot_store_table.sv
verif/tb_top.sv
